// File: hdl/lgc_pkg.sv
`default_nettype none

package lgc_pkg;

  localparam int Slots      = 64;
  localparam int SlotW      = $clog2(Slots);
  localparam int RankW      = SlotW;
  localparam int CfgW       = 7;
  localparam int SlotFieldW = 6;
  localparam int CodeW      = 16;
  localparam int PAddrW     = 3;
  localparam int PDataW     = 32;
  localparam int CmpW       = (SlotW + 1 > CfgW) ? SlotW + 1 : CfgW;

  localparam logic [CodeW-1:0] EmptyCode   = 16'hffff;
  localparam logic [CfgW-1:0]  ResetInUse  = 7'd64;
  // word index of the slots_in_use register (paddr[2])
  localparam logic             RegSlotsInUse = 1'b0;

  typedef logic [SlotW-1:0] lgc_slot_t;
  typedef logic [RankW-1:0] lgc_rank_t;

  typedef struct packed {
    logic [CodeW-1:0] glyph_code;
    logic             lookup_only;
  } lgc_req_t;

  typedef struct packed {
    logic                  hit;
    logic [SlotFieldW-1:0] slot;
    logic                  fill_needed;
    logic                  no_entry;
  } lgc_resp_t;

  typedef struct packed {
    lgc_slot_t idx;
    lgc_rank_t rank;
  } lgc_victim_t;

endpackage

`default_nettype wire

// File: hdl/lru_glyph_cache_lookup.sv
`default_nettype none

// fully associative glyph cache with least-recently-used replacement
//
// request channel: a word (glyph_code, lookup_only) is taken at a rising edge
//   with start high and busy low; busy is never raised, so a word may
//   be offered in every cycle
// result channel: done_o marks resp_o for exactly one cycle; the receiver
//   cannot stall, so every result is simply taken at the edge ending it
// result path: from the accepting edge through the request register, then
//   compare/update into the result register
// throughput: one word per cycle; the tag compare, the lowest-rank search
//   and the rank update all settle between the request register and the
//   state/result registers, so the next word sees the updated state
// config: apb port, slots_in_use at byte address 0, write only while idle
// reset: every slot holds 0xffff, slot i has rank i, slots_in_use is 64,
//   no result pending

module lru_glyph_cache_lookup
  import lgc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lgc_req_t          req_i,
  output logic              done_o,
  output lgc_resp_t         resp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [PDataW-1:0] pwdata,
  output logic [PDataW-1:0] prdata,
  output logic              pready
);

  // configuration
  logic [CfgW-1:0] cfg_q;

  // cache state
  logic [CodeW-1:0] code_q [Slots];
  lgc_rank_t        rank_q [Slots];

  // request and result registers
  logic      req_vld_q;
  lgc_req_t  req_q;
  logic      done_q;
  lgc_resp_t resp_q, resp_d;

  // lookup datapath
  logic [Slots-1:0] active;
  logic [Slots-1:0] match;
  logic             hit;
  lgc_slot_t        hit_idx;
  lgc_rank_t        hit_rank;
  lgc_victim_t      victim;
  logic             touch;
  lgc_slot_t        t_idx;
  lgc_rank_t        t_rank;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // ---------------------------------------------------------------------------
  // apb register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ResetInUse;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegSlotsInUse) begin
      cfg_q <= pwdata[CfgW-1:0];
    end
  end

  assign prdata = (paddr[2] == RegSlotsInUse) ? PDataW'(cfg_q) : '0;

  // ---------------------------------------------------------------------------
  // request register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  // ---------------------------------------------------------------------------
  // parallel tag compare; slot 0 is always active, a count above the slot
  // total naturally enables every slot
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      active[i] = (CmpW'(i) < CmpW'(cfg_q)) || (i == 0);
      match[i]  = active[i] && (code_q[i] == req_q.glyph_code);
    end
  end

  // lowest-numbered matching slot wins
  always_comb begin
    hit_idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = SlotW'(i);
      end
    end
  end

  assign hit      = |match;
  assign hit_rank = rank_q[hit_idx];

  // oldest active slot
  lgc_victim_find u_victim (
    .active_i (active),
    .rank_i   (rank_q),
    .victim_o (victim)
  );

  // the slot that becomes most recent, and its rank before the move
  assign touch  = req_vld_q && (hit || !req_q.lookup_only);
  assign t_idx  = hit ? hit_idx  : victim.idx;
  assign t_rank = hit ? hit_rank : victim.rank;

  // ---------------------------------------------------------------------------
  // state update: slots above the touched one age by one step, the touched
  // slot takes the top rank; a load writes the new code into the victim
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        code_q[i] <= EmptyCode;
        rank_q[i] <= RankW'(i);
      end
    end else if (touch) begin
      for (int i = 0; i < Slots; i++) begin
        if (SlotW'(i) == t_idx) begin
          rank_q[i] <= RankW'(Slots - 1);
          if (!hit) begin
            code_q[i] <= req_q.glyph_code;
          end
        end else if (rank_q[i] > t_rank) begin
          rank_q[i] <= rank_q[i] - 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_comb begin
    resp_d.hit         = hit;
    resp_d.fill_needed = !hit && !req_q.lookup_only;
    resp_d.no_entry    = !hit && req_q.lookup_only;
    resp_d.slot        = (!hit && req_q.lookup_only) ? '0 : SlotFieldW'(t_idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      resp_q <= resp_d;
    end
  end

  assign done_o = done_q;
  assign resp_o = resp_q;

endmodule

`default_nettype wire

// File: hdl/lgc_victim_find.sv
`default_nettype none

module lgc_victim_find
  import lgc_pkg::*;
(
  input  logic [Slots-1:0] active_i,
  input  lgc_rank_t        rank_i [Slots],
  output lgc_victim_t      victim_o
);

  localparam int Lvl  = $clog2(Slots);
  localparam int Pad  = 1 << Lvl;
  localparam int KeyW = RankW + 1;

  // key = {inactive, rank}: inactive slots always lose
  logic [KeyW-1:0] key [Lvl+1][Pad];
  lgc_slot_t       idx [Lvl+1][Pad];

  for (genvar p = 0; p < Pad; p++) begin : g_leaf
    if (p < Slots) begin : g_real
      assign key[0][p] = {~active_i[p], rank_i[p]};
      assign idx[0][p] = SlotW'(p);
    end else begin : g_pad
      assign key[0][p] = '1;
      assign idx[0][p] = '0;
    end
  end

  for (genvar l = 0; l < Lvl; l++) begin : g_lvl
    for (genvar p = 0; p < (Pad >> (l + 1)); p++) begin : g_node
      logic take_left;
      assign take_left     = key[l][2*p] <= key[l][2*p+1];
      assign key[l+1][p]   = take_left ? key[l][2*p] : key[l][2*p+1];
      assign idx[l+1][p]   = take_left ? idx[l][2*p] : idx[l][2*p+1];
    end
  end

  assign victim_o.idx  = idx[Lvl][0];
  assign victim_o.rank = key[Lvl][0][RankW-1:0];

endmodule

`default_nettype wire

// File: dv/lru_glyph_cache_lookup_tb.sv
`default_nettype none

// glyph cache check: a directed table of words, then random phases at
// several slots_in_use settings, every result compared with a local copy
// of the cache (codes, recency ranks, active slot count)

module lru_glyph_cache_lookup_tb;
  import lgc_pkg::*;

  // register map: word index sits on paddr[2]
  localparam logic [PAddrW-1:0] AddrSlotsInUse = {RegSlotsInUse, 2'b00};
  // one word past the map, writes there must be dropped
  localparam logic [PAddrW-1:0] AddrUnmapped   = {~RegSlotsInUse, 2'b00};

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 3;
  localparam int PhaseWords    = 205;
  localparam int NumPhases     = 9;
  localparam int NumDirected   = 18;
  localparam int MaxReported   = 10;

  // directed row: word to send, and a hand-worked result where one is obvious
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             lookup_only;
    logic             typed;
    lgc_resp_t        want;
  } directed_row_t;

  localparam lgc_resp_t NoneWant = '0;

  // the first five rows start from the reset state with all 64 slots active
  localparam directed_row_t DirectedRows [NumDirected] = '{
    // empty slots hold 0xffff, the lowest one answers
    '{16'hffff, 1'b1, 1'b1, '{hit: 1'b1, slot: 6'd0, fill_needed: 1'b0, no_entry: 1'b0}},
    // lookup-only miss, nothing loaded
    '{16'h0000, 1'b1, 1'b1, '{hit: 1'b0, slot: 6'd0, fill_needed: 1'b0, no_entry: 1'b1}},
    // slot 0 was just touched, so slot 1 is now the oldest
    '{16'h0000, 1'b0, 1'b1, '{hit: 1'b0, slot: 6'd1, fill_needed: 1'b1, no_entry: 1'b0}},
    '{16'h0000, 1'b1, 1'b1, '{hit: 1'b1, slot: 6'd1, fill_needed: 1'b0, no_entry: 1'b0}},
    // several slots still hold 0xffff, lowest numbered wins
    '{16'hffff, 1'b0, 1'b1, '{hit: 1'b1, slot: 6'd0, fill_needed: 1'b0, no_entry: 1'b0}},
    '{16'h8000, 1'b0, 1'b0, NoneWant},
    '{16'h7fff, 1'b0, 1'b0, NoneWant},
    '{16'h5555, 1'b0, 1'b0, NoneWant},
    '{16'haaaa, 1'b1, 1'b0, NoneWant},
    '{16'haaaa, 1'b0, 1'b0, NoneWant},
    '{16'h8000, 1'b1, 1'b0, NoneWant},
    '{16'h0001, 1'b0, 1'b0, NoneWant},
    '{16'hfffe, 1'b0, 1'b0, NoneWant},
    '{16'h7fff, 1'b1, 1'b0, NoneWant},
    '{16'h5555, 1'b0, 1'b0, NoneWant},
    '{16'h1234, 1'b1, 1'b0, NoneWant},
    '{16'hffff, 1'b1, 1'b0, NoneWant},
    '{16'h0000, 1'b0, 1'b0, NoneWant}
  };

  // slots_in_use per phase: the extremes 0, 1, 64 and 127 among them
  localparam logic [CfgW-1:0] PhaseCfg [NumPhases] = '{
    7'd1, 7'd0, 7'd127, 7'd2, 7'd65, 7'd40, 7'd63, 7'd3, 7'd64
  };

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  lgc_req_t          req_i   = '0;
  logic              done_o;
  lgc_resp_t         resp_o;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [PAddrW-1:0] paddr   = '0;
  logic [PDataW-1:0] pwdata  = '0;
  logic [PDataW-1:0] prdata;
  logic              pready;

  // hand-worked result travelling alongside the word on the request side
  logic              typed_on   = 1'b0;
  lgc_resp_t         typed_want = '0;

  lru_glyph_cache_lookup dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .done_o  (done_o),
    .resp_o  (resp_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // cache copy: codes, recency ranks (0 oldest) and the slot count register
  // ---------------------------------------------------------------------
  logic [CodeW-1:0] cached_code [Slots];
  logic [RankW-1:0] age_rank    [Slots];
  logic [CfgW-1:0]  slots_cfg;

  lgc_resp_t pending_resp_q [$];
  int        mismatch_count = 0;

  initial begin
    for (int i = 0; i < Slots; i++) begin
      cached_code[i] = EmptyCode;
      age_rank[i]    = RankW'(i);
    end
    slots_cfg = ResetInUse;
  end

  // 0 behaves as 1, anything past the slot count as the full cache
  function automatic int clamp_slots(logic [CfgW-1:0] cfg);
    int n;
    n = int'(cfg);
    if (n < 1) n = 1;
    if (n > Slots) n = Slots;
    return n;
  endfunction

  // touched slot becomes newest, everything newer than it ages by one;
  // inactive slots age too
  function automatic void promote(int s);
    logic [RankW-1:0] was;
    was = age_rank[s];
    for (int j = 0; j < Slots; j++) begin
      if (j != s && age_rank[j] > was) age_rank[j] = age_rank[j] - 1'b1;
    end
    age_rank[s] = RankW'(Slots - 1);
  endfunction

  function automatic lgc_resp_t cache_lookup(lgc_req_t word);
    int        n;
    int        found;
    int        victim;
    bit        matched;
    lgc_resp_t res;
    n       = clamp_slots(slots_cfg);
    matched = 1'b0;
    found   = 0;
    victim  = 0;
    for (int i = 0; i < n; i++) begin
      if (!matched && cached_code[i] == word.glyph_code) begin
        matched = 1'b1;
        found   = i;
      end
      if (age_rank[i] < age_rank[victim]) victim = i;
    end
    res = '0;
    if (matched) begin
      promote(found);
      res.hit  = 1'b1;
      res.slot = SlotFieldW'(found);
    end else if (word.lookup_only) begin
      res.no_entry = 1'b1;
    end else begin
      // evict the oldest active slot and ask for its bitmap
      cached_code[victim] = word.glyph_code;
      promote(victim);
      res.slot        = SlotFieldW'(victim);
      res.fill_needed = 1'b1;
    end
    return res;
  endfunction

  function automatic void flag_mismatch(string why, lgc_resp_t want, lgc_resp_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReported)
      $display({"mismatch (%s): want hit=%0b slot=%0d fill=%0b none=%0b,",
                " got hit=%0b slot=%0d fill=%0b none=%0b"},
               why, want.hit, want.slot, want.fill_needed, want.no_entry,
               got.hit, got.slot, got.fill_needed, got.no_entry);
  endfunction

  // ---------------------------------------------------------------------
  // monitor: everything sampled at the rising edge, before the block updates
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    lgc_resp_t oldest;
    lgc_resp_t predicted;
    if (rst_ni) begin
      // results first; a word taken at this edge cannot answer at the same edge
      if (done_o) begin
        if (pending_resp_q.size() == 0) begin
          flag_mismatch("unexpected word", '0, resp_o);
        end else begin
          oldest = pending_resp_q.pop_front();
          if (resp_o.hit !== oldest.hit || resp_o.slot !== oldest.slot ||
              resp_o.fill_needed !== oldest.fill_needed ||
              resp_o.no_entry !== oldest.no_entry)
            flag_mismatch("result field", oldest, resp_o);
        end
      end
      // register write; other indexes are dropped
      if (psel && penable && pwrite && pready && paddr == AddrSlotsInUse)
        slots_cfg = pwdata[CfgW-1:0];
      if (start && !busy) begin
        predicted = cache_lookup(req_i);
        if (typed_on) predicted = typed_want;
        pending_resp_q.push_back(predicted);
      end
    end
  end

  // watchdog: cycles in which neither side moves a word
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // drivers: everything changes at the falling edge
  // ---------------------------------------------------------------------
  task automatic send_word(input lgc_req_t word, input logic typed,
                           input lgc_resp_t want, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start      <= 1'b1;
    req_i      <= word;
    typed_on   <= typed;
    typed_want <= want;
    do @(posedge clk_i); while (busy);
  endtask

  // stop sending and wait for every outstanding result, plus the pipe depth
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_resp_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [PAddrW-1:0] addr, input logic [PDataW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    lgc_req_t         word;
    logic [PDataW-1:0] wdata;
    logic [CodeW-1:0] code_pool [96];
    int               pool_size;
    int               idle_pct;
    int               pick;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows at reset configuration, no gaps
    for (int r = 0; r < NumDirected; r++) begin
      word.glyph_code  = DirectedRows[r].code;
      word.lookup_only = DirectedRows[r].lookup_only;
      send_word(word, DirectedRows[r].typed, DirectedRows[r].want, 0);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      // a write past the register map must leave slots_in_use alone
      if (ph == 3) write_reg(AddrUnmapped, $urandom());
      wdata            = $urandom();
      wdata[CfgW-1:0]  = PhaseCfg[ph];
      write_reg(AddrSlotsInUse, wdata);

      // sender gaps: 37 in 100, then 56 in 100, then none
      idle_pct = (ph < 3) ? 37 : (ph < 6) ? 56 : 0;

      // a code pool a little larger than the active set keeps hits, misses
      // and evictions all common
      pool_size = clamp_slots(PhaseCfg[ph]);
      pool_size = pool_size + pool_size / 4 + 1;
      for (int k = 0; k < pool_size; k++) code_pool[k] = CodeW'($urandom());

      repeat (PhaseWords) begin
        pick = $urandom_range(99);
        if (pick < 75)
          word.glyph_code = code_pool[$urandom_range(pool_size - 1)];
        else if (pick < 90)
          word.glyph_code = CodeW'($urandom());
        else if (pick < 96)
          word.glyph_code = EmptyCode;
        else
          word.glyph_code = '0;
        word.lookup_only = ($urandom_range(99) < 25);
        send_word(word, 1'b0, NoneWant, idle_pct);
        // now and then hold off until the cache has answered everything
        if ($urandom_range(199) == 0) settle();
      end
    end

    settle();
    if (mismatch_count == 0 && pending_resp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (pending_resp_q.size() != 0)
        $display("%0d results never arrived", pending_resp_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
hdl/lgc_pkg.sv
hdl/lgc_victim_find.sv
hdl/lru_glyph_cache_lookup.sv
dv/lru_glyph_cache_lookup_tb.sv
